// ===== hw/rtl/csv_field_splitter_sjis_core_assert.svh =====
// assertion macros shared by the csv splitter rtl
// no dependencies; included by the modules that carry assertions
`ifndef CSV_FIELD_SPLITTER_SJIS_CORE_ASSERT_SVH
`define CSV_FIELD_SPLITTER_SJIS_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define CSVS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CSVS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CSVS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define CSVS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/csvs_pkg.sv =====
// types, constants and byte class helpers for the csv field splitter
// no dependencies; imported by every module of the block
package csvs_pkg;

  // one input transfer
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } in_item_t;

  // one result transfer
  typedef struct packed {
    logic       kind;
    logic [7:0] out_byte;
    logic       final_field;
  } res_item_t;

  // splitter state carried from byte to byte
  typedef struct packed {
    logic       held_valid;
    logic [7:0] held_byte;
    logic       in_quotes;
  } dec_state_t;

  localparam logic       KIND_DATA  = 1'b0;
  localparam logic       KIND_END   = 1'b1;
  localparam logic [7:0] QUOTE_BYTE = 8'h22;

  // results per input item and result queue sizing
  localparam int MAX_RES   = 3;
  localparam int RES_CNT_W = 2;
  localparam int RQ_DEPTH  = 4;
  localparam int RQ_PTR_W  = 2;
  localparam int RQ_CNT_W  = 3;

  // configuration register map
  localparam int         CFG_IDX_W        = 2;
  localparam logic [1:0] CFG_DELIM_FIRST  = 2'd0;
  localparam logic [1:0] CFG_DELIM_SECOND = 2'd1;
  localparam logic [7:0] DELIM_FIRST_RST  = 8'd44;
  localparam logic [7:0] DELIM_SECOND_RST = 8'd0;

  // shift-jis lead byte
  function automatic logic is_lead(input logic [7:0] b);
    return b inside {[8'h81:8'h9F], [8'hE0:8'hFC]};
  endfunction

  // shift-jis trail byte
  function automatic logic is_trail(input logic [7:0] b);
    return b inside {[8'h40:8'h7E], [8'h80:8'hFC]};
  endfunction

endpackage

// ===== hw/rtl/csv_field_splitter_sjis_core.sv =====
// top level of the shift-jis aware csv field splitter
// depends on csvs_pkg, csvs_decode, csvs_rq and the assertion macro header
//
// Usage:
//   in_valid/in_stall/in_data carry one string byte per transfer; end_of_string
//   marks the last byte. out_valid/out_stall/out_data carry one result per
//   transfer: a field data byte (kind 0) or a field end (kind 1, final_field
//   set on the end that closes the string). cfg_valid/cfg_ready with
//   cfg_index/cfg_data write the two delimiter registers; cfg_ready is always
//   high and writes are meant for idle periods.
//   A byte taken into the input register is decided there once its results fit
//   in the result queue, whose head entry drives the output. A lead byte or
//   quote waits for the next byte (or the string end) before it is decided.
//   Throughput: one byte per cycle while each byte yields at most one result
//   and the receiver does not stall; a byte giving two or three results drains
//   through the single-result output port of the four-entry result queue.
//   Reset clears the input register, the lookahead, quote mode and the result
//   queue, and sets the delimiters to comma and unused. When the receiver
//   stalls, results collect in the queue and in_stall rises once the results of
//   the registered byte cannot fit.
`include "csv_field_splitter_sjis_core_assert.svh"

module csv_field_splitter_sjis_core
  import csvs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output res_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic                 s1_valid_r, s1_valid_nxt;
  in_item_t             s1_item_r;
  dec_state_t           st_r, st_nxt;
  logic [7:0]           delim_first_r;
  logic [7:0]           delim_second_r;
  logic [RES_CNT_W-1:0] push_n;
  logic [RES_CNT_W-1:0] push_n_q;
  res_item_t            push_items [MAX_RES];
  logic [RQ_CNT_W-1:0]  free_cnt;
  logic                 fire;
  logic                 in_take;

  // decide the registered byte once its results fit in the queue
  assign fire     = s1_valid_r && ({1'b0, push_n} <= free_cnt);
  assign in_stall = s1_valid_r && !fire;
  assign in_take  = in_valid && !in_stall;
  assign push_n_q = fire ? push_n : '0;
  assign cfg_ready = 1'b1;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
    end
  end

  // lookahead and quote state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  // delimiter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_first_r  <= DELIM_FIRST_RST;
      delim_second_r <= DELIM_SECOND_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DELIM_FIRST:  delim_first_r  <= cfg_data;
        CFG_DELIM_SECOND: delim_second_r <= cfg_data;
        default: ;
      endcase
    end
  end

  csvs_decode u_decode (
    .item         (s1_item_r),
    .st           (st_r),
    .delim_first  (delim_first_r),
    .delim_second (delim_second_r),
    .st_nxt       (st_nxt),
    .push_n       (push_n),
    .push_items   (push_items)
  );

  csvs_rq u_rq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_n     (push_n_q),
    .push_items (push_items),
    .free_cnt   (free_cnt),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  `CSVS_ASSERT_IMP(a_held_is_lead_or_quote, clk, rst_n, st_r.held_valid,
    is_lead(st_r.held_byte) || (st_r.held_byte == QUOTE_BYTE), "held byte cannot pair")
  `CSVS_ASSERT_NXT(a_end_flushes_held, clk, rst_n, fire && s1_item_r.end_of_string,
    !st_r.held_valid, "lookahead survived a string end")
  `CSVS_ASSERT_IMP(a_end_gives_result, clk, rst_n, fire && s1_item_r.end_of_string,
    push_n != '0, "string end produced no field end")

endmodule

// ===== hw/rtl/csvs_decode.sv =====
// per-byte decision logic: pairs, quotes, delimiters and string end
// depends on csvs_pkg
module csvs_decode
  import csvs_pkg::*;
(
  input  in_item_t   item,
  input  dec_state_t st,
  input  logic [7:0] delim_first,
  input  logic [7:0] delim_second,
  output dec_state_t st_nxt,
  output logic [RES_CNT_W-1:0] push_n,
  output res_item_t  push_items [MAX_RES]
);

  typedef struct packed {
    logic      emit;
    res_item_t item;
    logic      toggle;
  } single_t;

  // decision for a byte that does not pair with its neighbor
  function automatic single_t single_byte(input logic [7:0] b, input logic q,
                                          input logic [7:0] df, input logic [7:0] ds);
    single_t s;
    logic    dm;
    s  = '0;
    dm = ((df != 8'd0) && (b == df)) || ((ds != 8'd0) && (b == ds));
    if (b == QUOTE_BYTE) begin
      s.toggle = 1'b1;
    end else if (q || !dm) begin
      s.emit          = 1'b1;
      s.item.kind     = KIND_DATA;
      s.item.out_byte = b;
    end else begin
      s.emit      = 1'b1;
      s.item.kind = KIND_END;
    end
    return s;
  endfunction

  // candidate results in output order, then packed into slots
  always_comb begin
    res_item_t            cand [4];
    logic [3:0]           cand_ok;
    single_t              s;
    logic                 q;
    logic                 hv;
    logic [7:0]           hb;
    logic [7:0]           b;
    logic [7:0]           h;
    logic                 fresh;
    logic [RES_CNT_W-1:0] n;

    for (int i = 0; i < 4; i++) cand[i] = '0;
    cand_ok = '0;
    q       = st.in_quotes;
    hv      = 1'b0;
    hb      = 8'd0;
    b       = item.data_byte;
    h       = st.held_byte;
    fresh   = 1'b1;

    // pending byte against the new one
    if (st.held_valid) begin
      if (is_lead(h) && is_trail(b)) begin
        cand[0].kind     = KIND_DATA;
        cand[0].out_byte = h;
        cand[1].kind     = KIND_DATA;
        cand[1].out_byte = b;
        cand_ok[1:0]     = 2'b11;
        fresh            = 1'b0;
      end else if ((h == QUOTE_BYTE) && (b == QUOTE_BYTE)) begin
        cand[0].kind     = KIND_DATA;
        cand[0].out_byte = QUOTE_BYTE;
        cand_ok[0]       = 1'b1;
        fresh            = 1'b0;
      end else begin
        s          = single_byte(h, q, delim_first, delim_second);
        cand[0]    = s.item;
        cand_ok[0] = s.emit;
        q          = q ^ s.toggle;
      end
    end

    // new byte that was not paired with the pending byte
    if (fresh) begin
      if (is_lead(b) || (b == QUOTE_BYTE)) begin
        hv = 1'b1;
        hb = b;
      end else begin
        s          = single_byte(b, q, delim_first, delim_second);
        cand[1]    = s.item;
        cand_ok[1] = s.emit;
        q          = q ^ s.toggle;
      end
    end

    // string end flushes the lookahead and closes the last field
    if (item.end_of_string) begin
      if (hv) begin
        s          = single_byte(hb, q, delim_first, delim_second);
        cand[2]    = s.item;
        cand_ok[2] = s.emit;
        q          = q ^ s.toggle;
        hv         = 1'b0;
        hb         = 8'd0;
      end
      cand[3].kind        = KIND_END;
      cand[3].final_field = 1'b1;
      cand_ok[3]          = 1'b1;
    end

    // pack the emitted candidates in order
    for (int i = 0; i < MAX_RES; i++) push_items[i] = '0;
    n = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand_ok[i]) begin
        case (n)
          2'd0:    push_items[0] = cand[i];
          2'd1:    push_items[1] = cand[i];
          2'd2:    push_items[2] = cand[i];
          default: ;
        endcase
        n = n + 2'd1;
      end
    end
    push_n = n;

    st_nxt.held_valid = hv;
    st_nxt.held_byte  = hb;
    st_nxt.in_quotes  = q;
  end

endmodule

// ===== hw/rtl/csvs_rq.sv =====
// result queue: takes up to three results per cycle, hands out one per transfer
// depends on csvs_pkg and the assertion macro header
`include "csv_field_splitter_sjis_core_assert.svh"

module csvs_rq
  import csvs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [RES_CNT_W-1:0] push_n,
  input  res_item_t            push_items [MAX_RES],
  output logic [RQ_CNT_W-1:0]  free_cnt,
  output logic                 out_valid,
  input  logic                 out_stall,
  output res_item_t            out_data
);

  res_item_t             mem_r [RQ_DEPTH];
  logic [RQ_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [RQ_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [RQ_CNT_W-1:0]   count_r, count_nxt;
  logic                  pop;

  // head entry drives the output
  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign free_cnt  = RQ_CNT_W'(RQ_DEPTH) - count_r;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RQ_PTR_W'(push_n);
    rd_ptr_nxt = rd_ptr_r + RQ_PTR_W'(pop);
    count_nxt  = count_r + RQ_CNT_W'(push_n) - RQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry writes, consecutive slots from the write pointer
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (RES_CNT_W'(i) < push_n) begin
        mem_r[wr_ptr_r + RQ_PTR_W'(i)] <= push_items[i];
      end
    end
  end

  `CSVS_ASSERT_IMP(a_rq_no_overflow, clk, rst_n, 1'b1,
    count_r <= RQ_CNT_W'(RQ_DEPTH), "result queue overfilled")
  `CSVS_ASSERT_IMP(a_rq_ptr_match, clk, rst_n, 1'b1,
    (wr_ptr_r - rd_ptr_r) == count_r[RQ_PTR_W-1:0], "queue pointers disagree with fill")
  `CSVS_ASSERT_NXT(a_rq_pop_drains, clk, rst_n, pop && (push_n == '0),
    count_r == $past(count_r) - 3'd1, "pop without push did not drain one entry")

endmodule
